// File: rtl/irf_pkg.sv
// Shared types, constants and helpers for the image rotate frame core.
// No dependencies; imported by every module under rtl/.
package irf_pkg;

    localparam int MAX_DIM    = 256;
    localparam int MAX_PIXELS = 65536;

    localparam int CNT_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = CNT_W + 1;
    localparam int ADDR_W    = $clog2(MAX_PIXELS);
    localparam int TOT_W     = ADDR_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    localparam logic [MODE_W-1:0] ROT_CW  = 2'd0;
    localparam logic [MODE_W-1:0] ROT_CCW = 2'd1;
    localparam logic [MODE_W-1:0] ROT_180 = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } irf_in_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       frame_last;
    } irf_out_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } irf_pix_t;

    // Controller to datapath
    typedef struct packed {
        logic load_we;
        logic step;
        logic addr_en;
        logic rd_en;
        logic out_load;
    } irf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fetch_op;
    } irf_sts_t;

    // Zero acts as one, anything above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/irf_ctrl.sv
// Sequencer for the image rotate frame core: handshakes and datapath commands.
// Depends on irf_pkg.
module irf_ctrl import irf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output irf_cmd_t cmd,
    input  irf_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_we = accept && (sts.fetch_op == OP_LOAD);
                cmd.step    = accept && (sts.fetch_op == OP_FETCH);
                if (cmd.step) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.addr_en = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/irf_datapath.sv
// Datapath of the image rotate frame core: configuration, walk counters,
// address generation, frame store and output register. Depends on irf_pkg.
module irf_datapath import irf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  irf_in_t              s_data,
    output irf_out_t             m_data,
    input  irf_cmd_t             cmd,
    output irf_sts_t             sts
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [ADDR_W-1:0] load_idx_reg;
    logic [ADDR_W-1:0] load_idx_next;
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  src_col_reg;
    logic [CNT_W-1:0]  src_row_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] addr_reg;
    irf_pix_t          rd_data_reg;
    irf_out_t          m_data_reg;
    irf_pix_t          mem [MAX_PIXELS];

    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  load_inc;
    logic              out_of_frame;
    logic [DIM_W-1:0]  col_cur;
    logic [DIM_W-1:0]  row_cur;
    logic [DIM_W-1:0]  col_inc;
    logic [DIM_W-1:0]  row_inc;
    logic [DIM_W-1:0]  col_rev;
    logic [DIM_W-1:0]  row_rev;
    logic [DIM_W-1:0]  src_col;
    logic [DIM_W-1:0]  src_row;
    logic [DIM_W-1:0]  col_next;
    logic [DIM_W-1:0]  row_next;
    logic              last_next;
    logic [TOT_W-1:0]  addr_calc;
    logic [ADDR_W-1:0] mem_addr;
    irf_pix_t          wr_pix;

    assign sts.fetch_op = s_data.op;
    assign m_data       = m_data_reg;

    assign w     = clamp_dim(width_reg);
    assign h     = clamp_dim(height_reg);
    assign total = TOT_W'(w) * TOT_W'(h);

    // wrap the load pointer at the end of the frame
    assign load_inc      = {1'b0, load_idx_reg} + TOT_W'(1);
    assign load_idx_next = (load_inc >= total) ? '0 : load_inc[ADDR_W-1:0];

    // restart the walk if a configuration change left it outside the frame
    assign out_of_frame = ({1'b0, col_reg} >= w) || ({1'b0, row_reg} >= h);
    assign col_cur      = out_of_frame ? '0 : {1'b0, col_reg};
    assign row_cur      = out_of_frame ? '0 : {1'b0, row_reg};
    assign col_inc      = col_cur + DIM_W'(1);
    assign row_inc      = row_cur + DIM_W'(1);
    assign col_rev      = w - DIM_W'(1) - col_cur;
    assign row_rev      = h - DIM_W'(1) - row_cur;

    always_comb begin
        case (mode_reg)
            ROT_180: begin
                src_col = col_rev;
                src_row = row_rev;
            end
            ROT_CCW: begin
                src_col = col_cur;
                src_row = row_rev;
            end
            default: begin
                src_col = col_rev;
                src_row = row_cur;
            end
        endcase
    end

    always_comb begin
        col_next  = col_cur;
        row_next  = row_cur;
        last_next = 1'b0;
        if (mode_reg == ROT_180) begin
            // row-major walk: column is the inner count
            if (col_inc == w) begin
                col_next = '0;
                if (row_inc == h) begin
                    row_next  = '0;
                    last_next = 1'b1;
                end else begin
                    row_next = row_inc;
                end
            end else begin
                col_next = col_inc;
            end
        end else begin
            // column-major walk: row is the inner count
            if (row_inc == h) begin
                row_next = '0;
                if (col_inc == w) begin
                    col_next  = '0;
                    last_next = 1'b1;
                end else begin
                    col_next = col_inc;
                end
            end else begin
                row_next = row_inc;
            end
        end
    end

    assign addr_calc = TOT_W'(src_row_reg) * TOT_W'(w) + TOT_W'(src_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(MAX_DIM);
            height_reg   <= DIM_W'(MAX_DIM);
            mode_reg     <= ROT_CW;
            load_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.load_we) begin
                load_idx_reg <= load_idx_next;
            end
            if (cmd.step) begin
                col_reg <= col_next[CNT_W-1:0];
                row_reg <= row_next[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            src_col_reg <= src_col[CNT_W-1:0];
            src_row_reg <= src_row[CNT_W-1:0];
            last_reg    <= last_next;
        end
        if (cmd.addr_en) begin
            addr_reg <= addr_calc[ADDR_W-1:0];
        end
        if (cmd.out_load) begin
            m_data_reg.out_blue   <= rd_data_reg.blue;
            m_data_reg.out_green  <= rd_data_reg.green;
            m_data_reg.out_red    <= rd_data_reg.red;
            m_data_reg.frame_last <= last_reg;
        end
    end

    // single-port frame store
    assign mem_addr     = cmd.load_we ? load_idx_reg : addr_reg;
    assign wr_pix.red   = s_data.in_red;
    assign wr_pix.green = s_data.in_green;
    assign wr_pix.blue  = s_data.in_blue;

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            mem[mem_addr] <= wr_pix;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

endmodule

// File: rtl/image_rotate_frame_core.sv
// Image rotate frame core: 90/180 degree frame rotator for 24-bit pixels.
// Load transactions are accepted back to back.
// A fetch transaction blocks the input through accept, address multiply,
// registered frame-store read and output load; the load waits for a free output register.
// Synchronous active-low reset clears the configuration, counters, state and handshakes;
// the frame store is not cleared and needs no clearing pass.
module image_rotate_frame_core import irf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  irf_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output irf_out_t             m_data
);

    irf_cmd_t cmd;
    irf_sts_t sts;

    assign cfg_ready = 1'b1;

    irf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    irf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a fetch transaction blocks the input on the following cycle
    a_fetch_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op == OP_FETCH) |=> !s_ready)
        else $error("input still ready after a fetch transaction");

    // ready only drops right after a fetch was taken
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && (s_data.op == OP_FETCH)))
        else $error("input ready dropped without a fetch transaction");

    // a new result only appears at the end of a fetch sequence
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while no fetch was in progress");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for image_rotate_frame_core: directed table, then random frames.
// Depends on rtl/irf_pkg.sv and rtl/image_rotate_frame_core.sv.
module tb_top;
    import irf_pkg::*;

    localparam int TOTAL_ITEMS    = 1400;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [MODE_W-1:0]    ROT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    localparam irf_pix_t PIX_BLACK   = 24'h000000;
    localparam irf_pix_t PIX_WHITE   = 24'hffffff;
    localparam irf_pix_t PIX_MAGENTA = 24'hff00ff;
    localparam irf_pix_t PIX_GREEN   = 24'h00ff00;
    localparam irf_pix_t PIX_MIXED   = 24'h3ca55a;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIM_W-1:0]     reg_val;
        irf_in_t              item;
        bit                   typed;
        irf_out_t             want;
    } dir_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    irf_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    irf_out_t             m_data;

    // Shadow of the core: registers, counters and frame store
    logic [DIM_W-1:0]  cur_width  = DIM_W'(MAX_DIM);
    logic [DIM_W-1:0]  cur_height = DIM_W'(MAX_DIM);
    logic [MODE_W-1:0] cur_mode   = ROT_CW;
    int                load_ptr   = 0;
    int                walk_col   = 0;
    int                walk_row   = 0;
    irf_pix_t          pix_mem     [MAX_PIXELS];
    bit                pix_written [MAX_PIXELS];

    irf_out_t pending_pixels[$];
    irf_out_t want;
    int       err_count     = 0;
    int       items_sent    = 0;
    int       n_accepted    = 0;
    int       n_results     = 0;
    int       n_frames      = 0;
    int       n_cfg_writes  = 0;
    int       stall_cycles  = 0;
    int       hold_requests = 0;
    int       holds_done    = 0;
    int       sink_wait     = 0;
    int       sink_run      = 0;

    image_rotate_frame_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int frame_pixels();
        return eff_dim(cur_width) * eff_dim(cur_height);
    endfunction

    // Source address of the next rotated pixel; advance the walk only on commit.
    function automatic void walk_next(input bit commit, output int addr, output bit is_last);
        int w, h, c, r, row, col;
        w = eff_dim(cur_width);
        h = eff_dim(cur_height);
        c = walk_col;
        r = walk_row;
        is_last = 1'b0;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        if (cur_mode == ROT_180) begin
            row = h - 1 - r;
            col = w - 1 - c;
            c++;
            if (c == w) begin
                c = 0;
                r++;
                if (r == h) begin
                    r = 0;
                    is_last = 1'b1;
                end
            end
        end else begin
            if (cur_mode == ROT_CCW) begin
                col = c;
                row = h - 1 - r;
            end else begin
                col = w - 1 - c;
                row = r;
            end
            r++;
            if (r == h) begin
                r = 0;
                c++;
                if (c == w) begin
                    c = 0;
                    is_last = 1'b1;
                end
            end
        end
        addr = row * w + col;
        if (commit) begin
            walk_col = c;
            walk_row = r;
        end
    endfunction

    // Apply one transaction to the shadow; return 1 with the rotated pixel on a fetch.
    function automatic bit rotate_item(input irf_in_t it, output irf_out_t res);
        int       a;
        bit       l;
        irf_pix_t p;
        res = '0;
        if (it.op == OP_LOAD) begin
            if (load_ptr < MAX_PIXELS) begin
                pix_mem[load_ptr]     = {it.in_red, it.in_green, it.in_blue};
                pix_written[load_ptr] = 1'b1;
            end
            load_ptr++;
            if (load_ptr >= frame_pixels()) load_ptr = 0;
            return 1'b0;
        end
        walk_next(1'b1, a, l);
        p   = pix_mem[a];
        res = '{out_blue: p.blue, out_green: p.green, out_red: p.red, frame_last: l};
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 8) return DIM_W'($urandom_range(MAX_DIM + 1, 2**DIM_W - 1));
        if (r < 80) return DIM_W'($urandom_range(1, 8));
        return DIM_W'($urandom_range(9, 24));
    endfunction

    function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] val);
        dir_row_t d;
        d = '{default: '0};
        d.is_cfg  = 1'b1;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    function automatic dir_row_t row_load(input irf_pix_t p);
        dir_row_t d;
        d = '{default: '0};
        d.item = '{op: OP_LOAD, in_blue: p.blue, in_green: p.green, in_red: p.red};
        return d;
    endfunction

    // Fetch colors are ignored by the core; drive them all ones.
    function automatic dir_row_t row_fetch(input irf_pix_t p, input bit is_last);
        dir_row_t d;
        d = '{default: '0};
        d.item  = '{op: OP_FETCH, in_blue: 8'hff, in_green: 8'hff, in_red: 8'hff};
        d.typed = 1'b1;
        d.want  = '{out_blue: p.blue, out_green: p.green, out_red: p.red,
                    frame_last: is_last};
        return d;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_item(input irf_in_t it, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_WIDTH:  cur_width  = val;
            CFG_HEIGHT: cur_height = val;
            CFG_MODE:   cur_mode   = val[MODE_W-1:0];
            default:    ;
        endcase
    endtask

    // Drain every pending pixel, then let trailing loads finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Fetch only where the next rotated pixel was stored; otherwise load.
    task automatic push_item(input bit want_fetch, input bit steady);
        irf_in_t  it;
        irf_out_t res;
        int       a;
        bit       l;
        it.in_blue  = 8'($urandom);
        it.in_green = 8'($urandom);
        it.in_red   = 8'($urandom);
        walk_next(1'b0, a, l);
        it.op = (want_fetch && pix_written[a]) ? OP_FETCH : OP_LOAD;
        if (rotate_item(it, res)) pending_pixels.push_back(res);
        send_item(it, steady ? 0 : pick_gap());
    endtask

    // Result side pacing, with one long hold-off per request
    always @(posedge aclk) begin : rx_pacing
        int gap;
        if (holds_done != hold_requests) begin
            holds_done <= hold_requests;
            sink_wait  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= (sink_wait == 1);
        end else if (sink_run > 0) begin
            sink_run <= sink_run - 1;
            m_ready  <= 1'b1;
        end else begin
            gap = pick_gap();
            sink_run  <= $urandom_range(1, 24);
            sink_wait <= gap;
            m_ready   <= (gap == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) n_accepted++;
            if (cfg_valid && cfg_ready) n_cfg_writes++;
            if (m_valid && m_ready) begin
                n_results++;
                if (m_data.frame_last) n_frames++;
                if (pending_pixels.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing pending",
                                           n_results));
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_data.out_blue !== want.out_blue)
                        report_error($sformatf("result %0d out_blue 0x%h, expected 0x%h",
                                               n_results, m_data.out_blue, want.out_blue));
                    if (m_data.out_green !== want.out_green)
                        report_error($sformatf("result %0d out_green 0x%h, expected 0x%h",
                                               n_results, m_data.out_green, want.out_green));
                    if (m_data.out_red !== want.out_red)
                        report_error($sformatf("result %0d out_red 0x%h, expected 0x%h",
                                               n_results, m_data.out_red, want.out_red));
                    if (m_data.frame_last !== want.frame_last)
                        report_error($sformatf("result %0d frame_last %b, expected %b",
                                               n_results, m_data.frame_last,
                                               want.frame_last));
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d pixels pending",
                     $time, stall_cycles, pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        dir_row_t          plan[$];
        irf_out_t          res;
        int                phase, n_load, n_fetch, n_mixed, total, n_directed;
        logic [DIM_W-1:0]  new_w, new_h;
        logic [MODE_W-1:0] new_mode;
        bit                wr_dims, wr_mode, steady;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 2x2 frame read back in every mode, then a 1x1 frame from zero dimensions
        plan.push_back(row_cfg(CFG_WIDTH, DIM_W'(2)));
        plan.push_back(row_cfg(CFG_HEIGHT, DIM_W'(2)));
        plan.push_back(row_cfg(CFG_MODE, DIM_W'(ROT_CW)));
        plan.push_back(row_load(PIX_BLACK));
        plan.push_back(row_load(PIX_WHITE));
        plan.push_back(row_load(PIX_MAGENTA));
        plan.push_back(row_load(PIX_GREEN));
        plan.push_back(row_fetch(PIX_WHITE, 1'b0));
        plan.push_back(row_fetch(PIX_GREEN, 1'b0));
        plan.push_back(row_fetch(PIX_BLACK, 1'b0));
        plan.push_back(row_fetch(PIX_MAGENTA, 1'b1));
        plan.push_back(row_cfg(CFG_MODE, DIM_W'(ROT_CCW)));
        plan.push_back(row_fetch(PIX_MAGENTA, 1'b0));
        plan.push_back(row_fetch(PIX_BLACK, 1'b0));
        plan.push_back(row_fetch(PIX_GREEN, 1'b0));
        plan.push_back(row_fetch(PIX_WHITE, 1'b1));
        plan.push_back(row_cfg(CFG_MODE, DIM_W'(ROT_180)));
        plan.push_back(row_fetch(PIX_GREEN, 1'b0));
        plan.push_back(row_fetch(PIX_MAGENTA, 1'b0));
        plan.push_back(row_fetch(PIX_WHITE, 1'b0));
        plan.push_back(row_fetch(PIX_BLACK, 1'b1));
        // unused mode code walks clockwise
        plan.push_back(row_cfg(CFG_MODE, DIM_W'(ROT_UNUSED)));
        plan.push_back(row_fetch(PIX_WHITE, 1'b0));
        plan.push_back(row_fetch(PIX_GREEN, 1'b0));
        plan.push_back(row_fetch(PIX_BLACK, 1'b0));
        plan.push_back(row_fetch(PIX_MAGENTA, 1'b1));
        plan.push_back(row_cfg(CFG_WIDTH, '0));
        plan.push_back(row_cfg(CFG_HEIGHT, '0));
        plan.push_back(row_load(PIX_MIXED));
        plan.push_back(row_fetch(PIX_MIXED, 1'b1));
        plan.push_back(row_cfg(CFG_SPARE, '1));
        plan.push_back(row_fetch(PIX_MIXED, 1'b1));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                cfg_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                if (rotate_item(plan[i].item, res))
                    pending_pixels.push_back(plan[i].typed ? plan[i].want : res);
                send_item(plan[i].item, pick_gap());
            end
        end
        n_directed = items_sent;

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            n_load  = 0;
            n_fetch = 0;
            n_mixed = 0;
            wr_dims = 1'b1;
            wr_mode = 1'b1;
            if (phase == 0) begin
                new_w    = DIM_W'(MAX_DIM);
                new_h    = DIM_W'(1);
                new_mode = ROT_CW;
            end else if (phase == 1) begin
                // 1 x 256 reads back what the 256 x 1 frame stored
                new_w    = DIM_W'(1);
                new_h    = DIM_W'(MAX_DIM);
                new_mode = ROT_CCW;
            end else if (phase % 9 == 2) begin
                new_w    = DIM_W'($urandom_range(6, 12));
                new_h    = DIM_W'($urandom_range(6, 12));
                new_mode = MODE_W'($urandom_range(0, 2));
            end else if ($urandom_range(0, 3) == 0) begin
                // change the walk order mid-frame
                wr_dims  = 1'b0;
                new_w    = cur_width;
                new_h    = cur_height;
                new_mode = MODE_W'($urandom_range(0, 3));
            end else begin
                new_w    = pick_dim();
                new_h    = pick_dim();
                new_mode = MODE_W'($urandom_range(0, 3));
                wr_mode  = 1'($urandom_range(0, 1));
                if (eff_dim(new_w) * eff_dim(new_h) > 400)
                    new_h = DIM_W'($urandom_range(0, 1));
            end
            if (wr_dims) begin
                cfg_write(CFG_WIDTH, new_w);
                cfg_write(CFG_HEIGHT, new_h);
            end
            if (wr_mode) cfg_write(CFG_MODE, DIM_W'(new_mode));

            total  = frame_pixels();
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                n_load  = total;
                n_fetch = total;
            end else if (phase == 1) begin
                n_fetch = total;
            end else if (phase % 9 == 2) begin
                n_load  = total;
                n_fetch = total;
                steady  = 1'b1;
                hold_requests++;
            end else if (!wr_dims) begin
                n_load  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                n_fetch = $urandom_range(1, (total < 200) ? total : 200);
            end else if ($urandom_range(0, 99) < 60) begin
                n_load  = (total < 200) ? total : 200;
                n_fetch = ($urandom_range(0, 99) < 70) ? total : $urandom_range(1, total);
                if (n_fetch > 200) n_fetch = 200;
            end else begin
                n_mixed = $urandom_range(10, 60);
            end

            repeat (n_load) push_item(1'b0, steady);
            repeat (n_fetch) push_item(1'b1, steady);
            repeat (n_mixed) push_item(1'($urandom_range(0, 1)), steady);
            phase++;
        end

        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d transactions (%0d directed) in %0d phases:",
                 n_accepted, n_directed, phase);
        $display("%0d pixels rotated, %0d frames, %0d register writes, %0d long hold-offs.",
                 n_results, n_frames, n_cfg_writes, holds_done);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", err_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: image_rotate_frame_core.f
rtl/irf_pkg.sv
rtl/irf_ctrl.sv
rtl/irf_datapath.sv
rtl/image_rotate_frame_core.sv
bench/tb_top.sv
